// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int WQ_PTR_W    = $clog2(WRITE_DEPTH + 1);
  localparam int WQ_IDX_W    = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_QUEUE = 2'd1,
    CMD_BEGIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_START_A    = 5'd1,
    PH_START_B    = 5'd2,
    PH_START_C    = 5'd3,
    PH_WR_LOW     = 5'd4,
    PH_WR_HIGH    = 5'd5,
    PH_WR_TAIL    = 5'd6,
    PH_WR_ACK     = 5'd7,
    PH_WR_AFTER   = 5'd8,
    PH_RS_A       = 5'd9,
    PH_RS_B       = 5'd10,
    PH_RS_C       = 5'd11,
    PH_RS_D       = 5'd12,
    PH_RD_STRETCH = 5'd13,
    PH_RD_HIGH    = 5'd14,
    PH_RD_LOW     = 5'd15,
    PH_RD_ACK_A   = 5'd16,
    PH_RD_ACK_B   = 5'd17,
    PH_RD_ACK_C   = 5'd18,
    PH_ST_A       = 5'd19,
    PH_ST_B       = 5'd20,
    PH_ST_C       = 5'd21
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_ADDR_W = 2'd0,
    ROLE_DATA   = 2'd1,
    ROLE_ADDR_R = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    AA_STOP    = 2'd0,
    AA_READ    = 2'd1,
    AA_WRITE   = 2'd2,
    AA_RESTART = 2'd3
  } after_ack_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        scl_in;
    logic        sda_in;
    logic [7:0]  data_byte;
    logic [6:0]  target_address;
    logic [1:0]  kind;
    logic [15:0] read_count;
  } req_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic       status;
  } rsp_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rewind;
    logic flush;
  } wq_ctrl_t;

endpackage

// ----- rtl/i2cm_if.sv -----
interface i2cm_req_if
  import i2cm_pkg::*;
  ();
  logic      valid;
  logic      ready;
  req_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_rsp_if
  import i2cm_pkg::*;
  ();
  logic      valid;
  logic      ready;
  rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/i2c_bus_master_core.sv -----
// I2C bus master core, stepped one bus tick per request beat.
// req channel: each beat is a command. A tick carries the sampled SCL and
// SDA levels and advances the bus sequencer by one time step; a queue
// beat stores a write byte and a begin beat starts a transfer (both only
// while idle). half_period_ticks (cfg_we/cfg_data) sets each bus delay.
// rsp channel: exactly one beat per request beat: line drives after the
// step (1 pulls low), busy, a completed read byte and end-of-transfer
// status.
// A request beat lands in the input register, is processed once the
// output register is free and its response beat is registered there.
// Throughput is one beat per cycle while rsp does not stall, set by the
// combinational sequencer update between input and output registers.
// Reset: sequencer idle, both lines released, write queue empty,
// half_period_ticks = 100.
// When rsp stalls the pending response is held, one more request beat is
// taken into the input register, then req.ready drops until rsp drains.
module i2c_bus_master_core
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2cm_req_if.sink    req,
  i2cm_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  logic [15:0] half_period_ticks;
  logic        in_valid;
  req_item_t   in_item;
  logic        out_valid;
  rsp_item_t   out_item;
  logic        out_free;
  logic        step;
  rsp_item_t   step_result;

  assign out_free    = !out_valid || rsp.ready;
  assign step        = in_valid && out_free;
  assign req.ready   = !in_valid || out_free;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= step_result;
    end
  end

  i2cm_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .item              (in_item),
    .half_period_ticks (half_period_ticks),
    .result            (step_result)
  );

endmodule

// ----- rtl/i2cm_wqueue.sv -----
module i2cm_wqueue
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  wq_ctrl_t   ctrl,
  input  logic [7:0] wr_byte,
  output logic [7:0] head,
  output logic       has_data
);

  logic [7:0]          mem [WRITE_DEPTH];
  logic [WQ_PTR_W-1:0] fill;
  logic [WQ_PTR_W-1:0] pointer;
  logic                full;

  assign full     = (fill == WQ_PTR_W'(WRITE_DEPTH));
  assign has_data = (pointer < fill);
  assign head     = mem[pointer[WQ_IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      mem[fill[WQ_IDX_W-1:0]] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      pointer <= '0;
    end else if (ctrl.flush) begin
      fill    <= '0;
      pointer <= '0;
    end else begin
      if (ctrl.push && !full) begin
        fill <= fill + WQ_PTR_W'(1);
      end
      if (ctrl.rewind) begin
        pointer <= '0;
      end else if (ctrl.pop) begin
        pointer <= pointer + WQ_PTR_W'(1);
      end
    end
  end

endmodule

// ----- rtl/i2cm_engine.sv -----
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  req_item_t   item,
  input  logic [15:0] half_period_ticks,
  output rsp_item_t   result
);

  phase_t      phase, phase_next;
  logic [15:0] delay_counter, delay_counter_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] reads_left, reads_left_next;
  logic [6:0]  saved_address, saved_address_next;
  logic [1:0]  saved_kind, saved_kind_next;
  logic        scl_drv, scl_drv_next;
  logic        sda_drv, sda_drv_next;
  logic        ack_seen, ack_seen_next;
  role_t       byte_role, byte_role_next;

  wq_ctrl_t    wq_ctrl;
  logic [7:0]  wq_head;
  logic        wq_has_data;

  logic        tick, idle, fire;
  logic        do_queue, do_begin;
  logic [15:0] limit, cnt_inc, reads_dec;
  logic [3:0]  bit_inc;
  logic [7:0]  shifted, addr_byte;
  after_ack_t  aa;

  i2cm_wqueue u_wqueue (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (wq_ctrl),
    .wr_byte  (item.data_byte),
    .head     (wq_head),
    .has_data (wq_has_data)
  );

  assign tick      = (cmd_t'(item.command) == CMD_TICK);
  assign idle      = (phase == PH_IDLE);
  assign do_queue  = idle && (cmd_t'(item.command) == CMD_QUEUE);
  assign do_begin  = idle && (cmd_t'(item.command) == CMD_BEGIN);
  assign limit     = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign cnt_inc   = delay_counter + 16'd1;
  assign fire      = tick && !idle && (phase != PH_RD_STRETCH) && (cnt_inc >= limit);
  assign bit_inc   = bit_counter + 4'd1;
  assign shifted   = {shift_byte[6:0], 1'b0};
  assign reads_dec = reads_left - 16'd1;
  assign addr_byte = {saved_address, saved_kind == KIND_READ};

  always_comb begin
    if (!ack_seen) begin
      aa = AA_STOP;
    end else if (byte_role == ROLE_ADDR_R || saved_kind == KIND_READ) begin
      aa = (reads_left != 16'd0) ? AA_READ : AA_STOP;
    end else if (wq_has_data) begin
      aa = AA_WRITE;
    end else if (saved_kind == KIND_RESTART) begin
      aa = AA_RESTART;
    end else begin
      aa = AA_STOP;
    end
  end

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (tick && phase == PH_RD_STRETCH) begin
      if (item.scl_in) begin
        phase_next = PH_RD_HIGH;
      end
    end else if (fire) begin
      unique case (phase)
        PH_START_A:  phase_next = PH_START_B;
        PH_START_B:  phase_next = PH_START_C;
        PH_START_C:  phase_next = PH_WR_LOW;
        PH_WR_LOW:   phase_next = PH_WR_HIGH;
        PH_WR_HIGH:  phase_next = (bit_inc < 4'd8) ? PH_WR_LOW : PH_WR_TAIL;
        PH_WR_TAIL:  phase_next = PH_WR_ACK;
        PH_WR_ACK:   phase_next = PH_WR_AFTER;
        PH_WR_AFTER: begin
          unique case (aa)
            AA_STOP:    phase_next = PH_ST_A;
            AA_READ:    phase_next = PH_RD_STRETCH;
            AA_WRITE:   phase_next = PH_WR_LOW;
            AA_RESTART: phase_next = PH_RS_A;
            default:    phase_next = PH_ST_A;
          endcase
        end
        PH_RS_A:     phase_next = PH_RS_B;
        PH_RS_B:     phase_next = PH_RS_C;
        PH_RS_C:     phase_next = PH_RS_D;
        PH_RS_D:     phase_next = PH_WR_LOW;
        PH_RD_HIGH:  phase_next = PH_RD_LOW;
        PH_RD_LOW:   phase_next = (bit_inc < 4'd8) ? PH_RD_STRETCH : PH_RD_ACK_A;
        PH_RD_ACK_A: phase_next = PH_RD_ACK_B;
        PH_RD_ACK_B: phase_next = PH_RD_ACK_C;
        PH_RD_ACK_C: phase_next = (reads_dec != 16'd0) ? PH_RD_STRETCH : PH_ST_A;
        PH_ST_A:     phase_next = PH_ST_B;
        PH_ST_B:     phase_next = PH_ST_C;
        PH_ST_C:     phase_next = PH_IDLE;
        default:     phase_next = phase;
      endcase
    end else if (do_begin) begin
      phase_next = PH_START_A;
    end
  end

  // datapath and result
  always_comb begin
    delay_counter_next = delay_counter;
    bit_counter_next   = bit_counter;
    shift_byte_next    = shift_byte;
    reads_left_next    = reads_left;
    saved_address_next = saved_address;
    saved_kind_next    = saved_kind;
    scl_drv_next       = scl_drv;
    sda_drv_next       = sda_drv;
    ack_seen_next      = ack_seen;
    byte_role_next     = byte_role;
    wq_ctrl            = '0;
    result             = '0;

    if (tick && phase == PH_RD_STRETCH) begin
      if (item.scl_in) begin
        delay_counter_next = '0;
      end
    end else if (tick && !idle) begin
      delay_counter_next = fire ? 16'd0 : cnt_inc;
    end

    if (fire) begin
      unique case (phase)
        PH_START_A: sda_drv_next = 1'b1;
        PH_START_B: scl_drv_next = 1'b1;
        PH_START_C: begin
          shift_byte_next  = addr_byte;
          bit_counter_next = '0;
          scl_drv_next     = 1'b1;
          sda_drv_next     = ~addr_byte[7];
          byte_role_next   = (saved_kind == KIND_READ) ? ROLE_ADDR_R : ROLE_ADDR_W;
        end
        PH_WR_LOW: scl_drv_next = 1'b0;
        PH_WR_HIGH: begin
          scl_drv_next     = 1'b1;
          shift_byte_next  = shifted;
          bit_counter_next = bit_inc;
          if (bit_inc < 4'd8) begin
            sda_drv_next = ~shifted[7];
          end
        end
        PH_WR_TAIL: begin
          scl_drv_next = 1'b0;
          sda_drv_next = 1'b0;
        end
        PH_WR_ACK: begin
          ack_seen_next = ~item.sda_in;
          scl_drv_next  = 1'b1;
        end
        PH_WR_AFTER: begin
          unique case (aa)
            AA_STOP: sda_drv_next = 1'b1;
            AA_READ: begin
              shift_byte_next  = '0;
              bit_counter_next = '0;
              scl_drv_next     = 1'b0;
              sda_drv_next     = 1'b0;
            end
            AA_WRITE: begin
              wq_ctrl.pop      = 1'b1;
              shift_byte_next  = wq_head;
              bit_counter_next = '0;
              scl_drv_next     = 1'b1;
              sda_drv_next     = ~wq_head[7];
              byte_role_next   = ROLE_DATA;
            end
            AA_RESTART: sda_drv_next = 1'b0;
            default:    sda_drv_next = 1'b1;
          endcase
        end
        PH_RS_A: scl_drv_next = 1'b0;
        PH_RS_B: sda_drv_next = 1'b1;
        PH_RS_C: scl_drv_next = 1'b1;
        PH_RS_D: begin
          shift_byte_next  = {saved_address, 1'b1};
          bit_counter_next = '0;
          scl_drv_next     = 1'b1;
          sda_drv_next     = ~saved_address[6];
          byte_role_next   = ROLE_ADDR_R;
        end
        PH_RD_HIGH: begin
          shift_byte_next = {shift_byte[6:0], item.sda_in};
          scl_drv_next    = 1'b1;
        end
        PH_RD_LOW: begin
          bit_counter_next = bit_inc;
          if (bit_inc < 4'd8) begin
            scl_drv_next = 1'b0;
          end else begin
            sda_drv_next = (reads_left > 16'd1);
          end
        end
        PH_RD_ACK_A: scl_drv_next = 1'b0;
        PH_RD_ACK_B: scl_drv_next = 1'b1;
        PH_RD_ACK_C: begin
          result.read_valid = 1'b1;
          result.read_byte  = shift_byte;
          reads_left_next   = reads_dec;
          if (reads_dec != 16'd0) begin
            shift_byte_next  = '0;
            bit_counter_next = '0;
            scl_drv_next     = 1'b0;
            sda_drv_next     = 1'b0;
          end else begin
            sda_drv_next = 1'b1;
          end
        end
        PH_ST_A: scl_drv_next = 1'b0;
        PH_ST_B: sda_drv_next = 1'b0;
        PH_ST_C: begin
          result.done_res = 1'b1;
          result.status   = ~ack_seen;
          wq_ctrl.flush   = 1'b1;
        end
        default: ;
      endcase
    end else if (do_queue) begin
      wq_ctrl.push = 1'b1;
    end else if (do_begin) begin
      saved_address_next = item.target_address;
      saved_kind_next    = item.kind;
      reads_left_next    = item.read_count;
      ack_seen_next      = 1'b0;
      scl_drv_next       = 1'b0;
      sda_drv_next       = 1'b0;
      delay_counter_next = '0;
      wq_ctrl.rewind     = 1'b1;
    end

    if (!step) begin
      wq_ctrl = '0;
    end

    result.scl_low  = scl_drv_next;
    result.sda_low  = sda_drv_next;
    result.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      delay_counter <= '0;
      bit_counter   <= '0;
      shift_byte    <= '0;
      reads_left    <= '0;
      saved_address <= '0;
      saved_kind    <= '0;
      scl_drv       <= 1'b0;
      sda_drv       <= 1'b0;
      ack_seen      <= 1'b0;
      byte_role     <= ROLE_ADDR_W;
    end else if (step) begin
      phase         <= phase_next;
      delay_counter <= delay_counter_next;
      bit_counter   <= bit_counter_next;
      shift_byte    <= shift_byte_next;
      reads_left    <= reads_left_next;
      saved_address <= saved_address_next;
      saved_kind    <= saved_kind_next;
      scl_drv       <= scl_drv_next;
      sda_drv       <= sda_drv_next;
      ack_seen      <= ack_seen_next;
      byte_role     <= byte_role_next;
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [15:0] cfg_data;

  i2cm_req_if req_ch ();
  i2cm_rsp_if rsp_ch ();

  i2c_bus_master_core dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bus sequencer mirror
  phase_t               bus_phase;
  logic [15:0]          tick_count;
  logic [3:0]           bits_done;
  logic [7:0]           shift_q;
  logic [7:0]           wq_mem [WRITE_DEPTH];
  logic [WQ_PTR_W-1:0]  wq_fill;
  logic [WQ_PTR_W-1:0]  wq_next;
  logic [15:0]          reads_due;
  logic [6:0]           addr_q;
  logic [1:0]           kind_q;
  logic                 scl_drv;
  logic                 sda_drv;
  logic                 acked;
  role_t                role_q;
  logic [15:0]          half_ticks;

  rsp_item_t bus_results_due [$];
  logic      ack_script [$];

  int fail_count = 0;
  int cycle_count = 0;
  int live_beats = 0;
  int transfers = 0;
  int bytes_read = 0;
  int nack_stops = 0;
  int sink_hold;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int nack_pct = 0;
  int stretch_pct = 20;
  int noise_pct = 0;

  function automatic void mirror_reset();
    bus_phase = PH_IDLE;
    tick_count = '0;
    bits_done = '0;
    shift_q = '0;
    foreach (wq_mem[i]) wq_mem[i] = '0;
    wq_fill = '0;
    wq_next = '0;
    reads_due = '0;
    addr_q = '0;
    kind_q = '0;
    scl_drv = 1'b0;
    sda_drv = 1'b0;
    acked = 1'b0;
    role_q = ROLE_ADDR_W;
    half_ticks = HALF_PERIOD_RESET;
  endfunction

  function automatic void enter(input phase_t p);
    bus_phase = p;
    tick_count = '0;
  endfunction

  function automatic void begin_write(input logic [7:0] b, input role_t role);
    role_q = role;
    shift_q = b;
    bits_done = '0;
    scl_drv = 1'b1;
    sda_drv = ~b[7];
    enter(PH_WR_LOW);
  endfunction

  function automatic void begin_read();
    shift_q = '0;
    bits_done = '0;
    scl_drv = 1'b0;
    sda_drv = 1'b0;
    enter(PH_RD_STRETCH);
  endfunction

  function automatic void begin_stop();
    sda_drv = 1'b1;
    enter(PH_ST_A);
  endfunction

  function automatic void after_ack();
    logic [7:0] b;
    if (!acked) begin
      begin_stop();
    end else if (role_q == ROLE_ADDR_R || kind_q == KIND_READ) begin
      if (reads_due != 0) begin_read();
      else begin_stop();
    end else if (wq_next < wq_fill && wq_next < WRITE_DEPTH) begin
      b = wq_mem[wq_next[WQ_IDX_W-1:0]];
      wq_next = wq_next + 1'b1;
      begin_write(b, ROLE_DATA);
    end else if (kind_q == KIND_RESTART) begin
      sda_drv = 1'b0;
      enter(PH_RS_A);
    end else begin
      begin_stop();
    end
  endfunction

  function automatic void finish_delay(input logic sda, inout rsp_item_t r);
    case (bus_phase)
      PH_START_A: begin sda_drv = 1'b1; enter(PH_START_B); end
      PH_START_B: begin scl_drv = 1'b1; enter(PH_START_C); end
      PH_START_C: begin
        if (kind_q == KIND_READ) begin_write({addr_q, 1'b1}, ROLE_ADDR_R);
        else begin_write({addr_q, 1'b0}, ROLE_ADDR_W);
      end
      PH_WR_LOW: begin scl_drv = 1'b0; enter(PH_WR_HIGH); end
      PH_WR_HIGH: begin
        scl_drv = 1'b1;
        shift_q = shift_q << 1;
        bits_done = bits_done + 1'b1;
        if (bits_done < 8) begin
          sda_drv = ~shift_q[7];
          enter(PH_WR_LOW);
        end else begin
          enter(PH_WR_TAIL);
        end
      end
      PH_WR_TAIL: begin scl_drv = 1'b0; sda_drv = 1'b0; enter(PH_WR_ACK); end
      PH_WR_ACK: begin acked = ~sda; scl_drv = 1'b1; enter(PH_WR_AFTER); end
      PH_WR_AFTER: after_ack();
      PH_RS_A: begin scl_drv = 1'b0; enter(PH_RS_B); end
      PH_RS_B: begin sda_drv = 1'b1; enter(PH_RS_C); end
      PH_RS_C: begin scl_drv = 1'b1; enter(PH_RS_D); end
      PH_RS_D: begin_write({addr_q, 1'b1}, ROLE_ADDR_R);
      PH_RD_HIGH: begin
        shift_q = {shift_q[6:0], sda};
        scl_drv = 1'b1;
        enter(PH_RD_LOW);
      end
      PH_RD_LOW: begin
        bits_done = bits_done + 1'b1;
        if (bits_done < 8) begin
          scl_drv = 1'b0;
          enter(PH_RD_STRETCH);
        end else begin
          sda_drv = (reads_due > 16'd1);
          enter(PH_RD_ACK_A);
        end
      end
      PH_RD_ACK_A: begin scl_drv = 1'b0; enter(PH_RD_ACK_B); end
      PH_RD_ACK_B: begin scl_drv = 1'b1; enter(PH_RD_ACK_C); end
      PH_RD_ACK_C: begin
        sda_drv = 1'b0;
        r.read_valid = 1'b1;
        r.read_byte = shift_q;
        reads_due = reads_due - 16'd1;
        if (reads_due != 0) begin_read();
        else begin_stop();
      end
      PH_ST_A: begin scl_drv = 1'b0; enter(PH_ST_B); end
      PH_ST_B: begin sda_drv = 1'b0; enter(PH_ST_C); end
      default: begin
        r.done_res = 1'b1;
        r.status = ~acked;
        wq_fill = '0;
        wq_next = '0;
        enter(PH_IDLE);
      end
    endcase
  endfunction

  function automatic rsp_item_t i2c_step(input req_item_t it);
    rsp_item_t r;
    logic [15:0] lim;
    r = '0;
    lim = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
    case (it.command)
      CMD_TICK: begin
        if (bus_phase == PH_RD_STRETCH) begin
          if (it.scl_in) enter(PH_RD_HIGH);
        end else if (bus_phase != PH_IDLE) begin
          tick_count = tick_count + 16'd1;
          if (tick_count >= lim) finish_delay(it.sda_in, r);
        end
      end
      CMD_QUEUE: begin
        if (bus_phase == PH_IDLE && wq_fill < WRITE_DEPTH) begin
          wq_mem[wq_fill[WQ_IDX_W-1:0]] = it.data_byte;
          wq_fill = wq_fill + 1'b1;
        end
      end
      CMD_BEGIN: begin
        if (bus_phase == PH_IDLE) begin
          addr_q = it.target_address;
          kind_q = it.kind;
          reads_due = it.read_count;
          wq_next = '0;
          acked = 1'b0;
          scl_drv = 1'b0;
          sda_drv = 1'b0;
          enter(PH_START_A);
        end
      end
      default: ;
    endcase
    r.scl_low = scl_drv;
    r.sda_low = sda_drv;
    r.busy_res = (bus_phase != PH_IDLE);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [6:0] rand_addr();
    return 7'($urandom_range(127));
  endfunction

  function automatic req_item_t any_beat();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(req_item_t)-1:0];
  endfunction

  function automatic req_item_t tick_beat();
    req_item_t it;
    logic [15:0] lim;
    it = any_beat();
    it.command = CMD_TICK;
    lim = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
    if (bus_phase == PH_RD_STRETCH) begin
      it.scl_in = ($urandom_range(99) >= stretch_pct);
    end else if (bus_phase == PH_WR_ACK && tick_count + 16'd1 >= lim) begin
      // this tick samples the acknowledge bit
      if (ack_script.size() != 0) it.sda_in = ack_script.pop_front();
      else it.sda_in = ($urandom_range(99) < nack_pct);
    end
    return it;
  endfunction

  function automatic req_item_t stray_beat();
    req_item_t it;
    it = any_beat();
    if (bus_phase == PH_IDLE) begin
      if ($urandom_range(1) != 0) it.command = CMD_NONE;
      else it.command = CMD_TICK;
    end else begin
      case ($urandom_range(2))
        0: it.command = CMD_QUEUE;
        1: it.command = CMD_BEGIN;
        default: it.command = CMD_NONE;
      endcase
    end
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_bus_result(input rsp_item_t got);
    rsp_item_t want;
    if (bus_results_due.size() == 0) begin
      $error("response beat with nothing pending: %h", got);
      fail_count++;
      return;
    end
    want = bus_results_due.pop_front();
    check_field("scl_low", 8'(want.scl_low), 8'(got.scl_low));
    check_field("sda_low", 8'(want.sda_low), 8'(got.sda_low));
    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
    check_field("read_byte", want.read_byte, got.read_byte);
    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
    check_field("status", 8'(want.status), 8'(got.status));
    if (want.read_valid) bytes_read++;
    if (want.done_res && want.status) nack_stops++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_bus_result(rsp_ch.payload);
      if (sink_hold != 0) begin
        rsp_ch.ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (sink_stalls && $urandom_range(99) < 30) sink_hold <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_beat(input req_item_t it);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= it;
    do @(posedge clk); while (!req_ch.ready);
    if (bus_phase != PH_IDLE ? it.command == CMD_TICK
                             : (it.command == CMD_QUEUE || it.command == CMD_BEGIN))
      live_beats++;
    bus_results_due.push_back(i2c_step(it));
  endtask

  task automatic wait_bus_results();
    req_ch.valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [15:0] v);
    wait_bus_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    half_ticks = v;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    req_item_t it;
    it = any_beat();
    it.command = CMD_QUEUE;
    it.data_byte = b;
    send_beat(it);
  endtask

  task automatic start_transfer(input logic [6:0] addr, input logic [1:0] kind,
                                input int n_queue, input logic [15:0] reads);
    req_item_t it;
    repeat (n_queue) queue_byte(8'($urandom_range(255)));
    it = any_beat();
    it.command = CMD_BEGIN;
    it.target_address = addr;
    it.kind = kind;
    it.read_count = reads;
    send_beat(it);
    transfers++;
  endtask

  task automatic run_to_idle();
    while (bus_phase != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) send_beat(stray_beat());
      else send_beat(tick_beat());
    end
  endtask

  task automatic do_transfer(input logic [6:0] addr, input logic [1:0] kind,
                             input int n_queue, input logic [15:0] reads);
    start_transfer(addr, kind, n_queue, reads);
    run_to_idle();
  endtask

  // reset period of 100: the first start delay ends on the 100th tick
  task automatic test_default_period();
    repeat (4) send_beat(stray_beat());
    start_transfer(rand_addr(), KIND_READ, 0, 16'd0);
    repeat (105) send_beat(tick_beat());
    write_half_period(16'd1);
    run_to_idle();
  endtask

  task automatic test_read_acks();
    do_transfer(7'h00, KIND_READ, 3, 16'd2);
  endtask

  task automatic test_restart();
    do_transfer(rand_addr(), KIND_RESTART, 1, 16'd1);
  endtask

  task automatic test_spare_kind();
    do_transfer(rand_addr(), KIND_SPARE, 1, 16'd1);
  endtask

  task automatic test_nacks();
    ack_script = '{1'b1};
    do_transfer(rand_addr(), KIND_READ, 0, 16'hFFFF);
    ack_script = '{1'b0, 1'b0, 1'b1};
    do_transfer(rand_addr(), KIND_WRITE, 2, 16'd0);
  endtask

  task automatic test_queue_full();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    do_transfer(7'h7F, KIND_WRITE, WRITE_DEPTH, 16'd0);
  endtask

  task automatic test_busy_commands();
    noise_pct = 40;
    do_transfer(rand_addr(), KIND_RESTART, 0, 16'd1);
    noise_pct = 0;
  endtask

  task automatic test_clock_stretch();
    stretch_pct = 85;
    do_transfer(rand_addr(), KIND_READ, 0, 16'd1);
    stretch_pct = 20;
  endtask

  task automatic test_zero_period();
    write_half_period(16'd0);
    do_transfer(rand_addr(), KIND_READ, 0, 16'd1);
  endtask

  task automatic test_random_traffic();
    int start;
    int r;
    start = live_beats;
    while (live_beats - start < 120) begin
      if ($urandom_range(5) == 0) write_half_period(16'($urandom_range(3, 1)));
      src_gaps = ($urandom_range(3) != 0);
      sink_stalls = ($urandom_range(3) != 0);
      r = $urandom_range(9);
      nack_pct = (r < 6) ? 0 : (r < 9) ? 8 : 40;
      stretch_pct = $urandom_range(60);
      noise_pct = $urandom_range(10);
      if ($urandom_range(99) < 15) repeat ($urandom_range(3, 1)) send_beat(stray_beat());
      do_transfer(rand_addr(), 2'($urandom_range(3)),
                  ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(18, 4),
                  16'(($urandom_range(99) < 85) ? $urandom_range(3)
                                                 : $urandom_range(6, 4)));
    end
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    nack_pct = 0;
    stretch_pct = 20;
    noise_pct = 0;
  endtask

  // delay far longer than the run: the sequencer must sit in the start phase
  task automatic test_slow_period();
    write_half_period(16'hFFFF);
    start_transfer(rand_addr(), KIND_RESTART, 1, 16'hFFFF);
    repeat (40) send_beat(tick_beat());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    mirror_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_period();
    test_read_acks();
    test_restart();
    test_spare_kind();
    test_nacks();
    test_queue_full();
    test_busy_commands();
    test_clock_stretch();
    test_zero_period();
    test_random_traffic();
    test_slow_period();
    wait_bus_results();

    $display("Covered %0d bus beats in %0d transfers, half periods 0 to 65535.",
             live_beats, transfers);
    $display("%0d bytes read back, %0d transfers stopped on a missing ack.",
             bytes_read, nack_stops);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
